FILE: rtl/core/pfu_pkg.sv
// Shared constants, types and helper functions for the pixel effect unit.
`timescale 1ns / 1ps

package pfu_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [2:0] MODE_PASS    = 3'd0;
    localparam logic [2:0] MODE_GRAY    = 3'd1;
    localparam logic [2:0] MODE_FACE    = 3'd2;
    localparam logic [2:0] MODE_BGND    = 3'd3;
    localparam logic [2:0] MODE_REDEYE  = 3'd4;
    localparam logic [2:0] MODE_ENCRYPT = 3'd5;
    localparam logic [2:0] MODE_DECRYPT = 3'd6;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EYE_X    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EYE_Y    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EYE_RAD  = 3'd5;

    localparam int WIDTH_RST   = 320;
    localparam int HEIGHT_RST  = 240;
    localparam int EYE_X_RST   = 160;
    localparam int EYE_Y_RST   = 200;
    localparam int EYE_RAD_RST = 70;

    localparam logic [15:0] LUMA_R_WEIGHT = 16'd19595;
    localparam logic [15:0] LUMA_G_WEIGHT = 16'd38470;
    localparam logic [15:0] LUMA_B_WEIGHT = 16'd7471;

    localparam logic [7:0] BGND_THRESHOLD = 8'd190;
    localparam logic [7:0] BGND_RED       = 8'd110;
    localparam logic [7:0] BGND_GREEN     = 8'd110;
    localparam logic [7:0] BGND_BLUE      = 8'd255;
    localparam logic [7:0] DARK_THRESHOLD = 8'd25;
    localparam logic [7:0] CIPHER_MASK    = 8'd128;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    function automatic logic [7:0] luma8(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        logic [23:0] sum;
        sum = {16'd0, r} * {8'd0, LUMA_R_WEIGHT}
            + {16'd0, g} * {8'd0, LUMA_G_WEIGHT}
            + {16'd0, b} * {8'd0, LUMA_B_WEIGHT};
        return sum[23:16];
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] t;
        t = {v, v} << n;
        return t[15:8];
    endfunction

    function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] t;
        t = {v, v} >> n;
        return t[7:0];
    endfunction

endpackage

FILE: rtl/core/pfu_cfg_regs.sv
// Configuration register file with the derived face circle geometry.
`timescale 1ns / 1ps

module pfu_cfg_regs
    import pfu_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data,
    output logic [2:0]                mode,
    output logic [COORD_BITS-1:0]     image_width,
    output logic [COORD_BITS-1:0]     eye_centre_x,
    output logic [COORD_BITS-1:0]     eye_centre_y,
    output logic [COORD_BITS-1:0]     eye_radius,
    output logic [COORD_BITS-1:0]     face_centre_x,
    output logic [COORD_BITS-1:0]     face_centre_y,
    output logic [COORD_BITS-1:0]     face_radius
);

    localparam logic [COORD_BITS-1:0] W0 = COORD_BITS'(WIDTH_RST);
    localparam logic [COORD_BITS-1:0] H0 = COORD_BITS'(HEIGHT_RST);
    localparam logic [COORD_BITS-1:0] FACE_R0 = H0 / 3;
    localparam int THIRD_SHIFT = COORD_BITS + 2;
    localparam logic [COORD_BITS:0] THIRD_MUL =
        (COORD_BITS + 1)'(((1 << THIRD_SHIFT) + 2) / 3);

    logic [2:0]            mode_reg, mode_next;
    logic [COORD_BITS-1:0] width_reg, width_next;
    logic [COORD_BITS-1:0] height_reg, height_next;
    logic [COORD_BITS-1:0] eye_x_reg, eye_x_next;
    logic [COORD_BITS-1:0] eye_y_reg, eye_y_next;
    logic [COORD_BITS-1:0] eye_rad_reg, eye_rad_next;
    logic [COORD_BITS-1:0] face_r_reg, face_r_next;
    logic [2*COORD_BITS:0] third_prod;

    always_comb
    begin
        mode_next    = mode_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        eye_x_next   = eye_x_reg;
        eye_y_next   = eye_y_reg;
        eye_rad_next = eye_rad_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:    mode_next    = cfg_data[2:0];
                REG_WIDTH:   width_next   = cfg_data;
                REG_HEIGHT:  height_next  = cfg_data;
                REG_EYE_X:   eye_x_next   = cfg_data;
                REG_EYE_Y:   eye_y_next   = cfg_data;
                REG_EYE_RAD: eye_rad_next = cfg_data;
                default:     ;
            endcase
        end
    end

    // The radius is a third of the height, taken as a multiply by a scaled reciprocal.
    assign third_prod  = {{(COORD_BITS + 1){1'b0}}, height_next} *
                         {{COORD_BITS{1'b0}}, THIRD_MUL};
    assign face_r_next = {1'b0, third_prod[2*COORD_BITS:THIRD_SHIFT]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_PASS;
            width_reg   <= W0;
            height_reg  <= H0;
            eye_x_reg   <= COORD_BITS'(EYE_X_RST);
            eye_y_reg   <= COORD_BITS'(EYE_Y_RST);
            eye_rad_reg <= COORD_BITS'(EYE_RAD_RST);
            face_r_reg  <= FACE_R0;
        end
        else
        begin
            mode_reg    <= mode_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            eye_x_reg   <= eye_x_next;
            eye_y_reg   <= eye_y_next;
            eye_rad_reg <= eye_rad_next;
            face_r_reg  <= face_r_next;
        end
    end

    assign mode          = mode_reg;
    assign image_width   = width_reg;
    assign eye_centre_x  = eye_x_reg;
    assign eye_centre_y  = eye_y_reg;
    assign eye_radius    = eye_rad_reg;
    assign face_centre_x = width_reg >> 1;
    assign face_centre_y = height_reg >> 1;
    assign face_radius   = face_r_reg;

endmodule

FILE: rtl/core/pfu_circle.sv
// Test of whether a point lies inside or on a circle.
`timescale 1ns / 1ps

module pfu_circle
    import pfu_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic [COORD_BITS-1:0] px,
    input  logic [COORD_BITS-1:0] py,
    input  logic [COORD_BITS-1:0] cx,
    input  logic [COORD_BITS-1:0] cy,
    input  logic [COORD_BITS-1:0] rad,
    output logic                  hit
);

    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic [2*COORD_BITS-1:0] dx2;
    logic [2*COORD_BITS-1:0] dy2;
    logic [2*COORD_BITS-1:0] r2;
    logic [2*COORD_BITS:0]   d2;

    assign dx  = (px >= cx) ? (px - cx) : (cx - px);
    assign dy  = (py >= cy) ? (py - cy) : (cy - py);
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;
    assign r2  = rad * rad;
    assign d2  = {1'b0, dx2} + {1'b0, dy2};
    assign hit = (d2 <= {1'b0, r2});

endmodule

FILE: rtl/core/pfu_effect.sv
// Per-pixel effect logic selected by the mode register.
`timescale 1ns / 1ps

module pfu_effect
    import pfu_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic [2:0]            mode,
    input  pixel_t                pix_in,
    input  logic [COORD_BITS-1:0] x_coord,
    input  logic [COORD_BITS-1:0] y_coord,
    input  logic [COORD_BITS-1:0] image_width,
    input  logic [COORD_BITS-1:0] eye_centre_x,
    input  logic [COORD_BITS-1:0] eye_centre_y,
    input  logic [COORD_BITS-1:0] eye_radius,
    input  logic [COORD_BITS-1:0] face_centre_x,
    input  logic [COORD_BITS-1:0] face_centre_y,
    input  logic [COORD_BITS-1:0] face_radius,
    output pixel_t                pix_out
);

    logic       in_face;
    logic       in_eye;
    logic [7:0] gray;
    logic [5:0] wy_low;
    logic [2:0] rot;
    logic       bright;
    logic       dark;

    pfu_circle #(.COORD_BITS(COORD_BITS)) u_face_circle
    (
        .px     (x_coord),
        .py     (y_coord),
        .cx     (face_centre_x),
        .cy     (face_centre_y),
        .rad    (face_radius),
        .hit    (in_face)
    );

    pfu_circle #(.COORD_BITS(COORD_BITS)) u_eye_circle
    (
        .px     (x_coord),
        .py     (y_coord),
        .cx     (eye_centre_x),
        .cy     (eye_centre_y),
        .rad    (eye_radius),
        .hit    (in_eye)
    );

    // Only the low three bits of the linear pixel index set the rotation.
    assign wy_low = image_width[2:0] * y_coord[2:0];
    assign rot    = x_coord[2:0] + wy_low[2:0];
    assign gray   = luma8(pix_in.red, pix_in.green, pix_in.blue);
    assign bright = (pix_in.red >= BGND_THRESHOLD) && (pix_in.green >= BGND_THRESHOLD) &&
                    (pix_in.blue >= BGND_THRESHOLD);
    assign dark   = (pix_in.red < DARK_THRESHOLD) && (pix_in.green < DARK_THRESHOLD) &&
                    (pix_in.blue < DARK_THRESHOLD);

    always_comb
    begin
        pix_out = pix_in;
        case (mode)
            MODE_GRAY:
            begin
                pix_out = '{gray, gray, gray};
            end
            MODE_FACE:
            begin
                if (!in_face)
                begin
                    pix_out = '{gray, gray, gray};
                end
            end
            MODE_BGND:
            begin
                if (bright)
                begin
                    pix_out = '{BGND_RED, BGND_GREEN, BGND_BLUE};
                end
            end
            MODE_REDEYE:
            begin
                if (in_eye && dark)
                begin
                    pix_out = '{8'hFF, 8'h00, 8'h00};
                end
            end
            MODE_ENCRYPT:
            begin
                pix_out.red   = rotl8(pix_in.red, rot) ^ CIPHER_MASK;
                pix_out.green = rotl8(pix_in.green, rot) ^ CIPHER_MASK;
                pix_out.blue  = rotl8(pix_in.blue, rot) ^ CIPHER_MASK;
            end
            MODE_DECRYPT:
            begin
                pix_out.red   = rotr8(pix_in.red ^ CIPHER_MASK, rot);
                pix_out.green = rotr8(pix_in.green ^ CIPHER_MASK, rot);
                pix_out.blue  = rotr8(pix_in.blue ^ CIPHER_MASK, rot);
            end
            default:
            begin
                pix_out = pix_in;
            end
        endcase
    end

endmodule

FILE: rtl/core/pixel_effect_unit.sv
// Top level of the pixel effect unit: input register, effect logic and result register.
// Accepted pixels pass from the input register via the effect logic to the result register.
// Throughput: one pixel per cycle while out_stall is low; the input and result registers
// form a two-entry pipeline, so input is stalled only while both are full and the result waits.
// Reset clears the pipeline valid flags and returns the registers to their defaults.
`timescale 1ns / 1ps

module pixel_effect_unit
    import pfu_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                red_in,
    input  logic [7:0]                green_in,
    input  logic [7:0]                blue_in,
    input  logic [COORD_BITS-1:0]     x_coord,
    input  logic [COORD_BITS-1:0]     y_coord,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                red_out,
    output logic [7:0]                green_out,
    output logic [7:0]                blue_out
);

    logic [2:0]            mode;
    logic [COORD_BITS-1:0] image_width;
    logic [COORD_BITS-1:0] eye_centre_x;
    logic [COORD_BITS-1:0] eye_centre_y;
    logic [COORD_BITS-1:0] eye_radius;
    logic [COORD_BITS-1:0] face_centre_x;
    logic [COORD_BITS-1:0] face_centre_y;
    logic [COORD_BITS-1:0] face_radius;

    logic                  s1_valid_reg, s1_valid_next;
    pixel_t                s1_pix_reg;
    logic [COORD_BITS-1:0] s1_x_reg;
    logic [COORD_BITS-1:0] s1_y_reg;
    logic                  s2_valid_reg, s2_valid_next;
    pixel_t                s2_pix_reg;
    pixel_t                effect_pix;
    logic                  s1_ready;
    logic                  s2_ready;
    logic                  s1_load;
    logic                  s2_load;

    pfu_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .image_width   (image_width),
        .eye_centre_x  (eye_centre_x),
        .eye_centre_y  (eye_centre_y),
        .eye_radius    (eye_radius),
        .face_centre_x (face_centre_x),
        .face_centre_y (face_centre_y),
        .face_radius   (face_radius)
    );

    pfu_effect #(.COORD_BITS(COORD_BITS)) u_effect
    (
        .mode          (mode),
        .pix_in        (s1_pix_reg),
        .x_coord       (s1_x_reg),
        .y_coord       (s1_y_reg),
        .image_width   (image_width),
        .eye_centre_x  (eye_centre_x),
        .eye_centre_y  (eye_centre_y),
        .eye_radius    (eye_radius),
        .face_centre_x (face_centre_x),
        .face_centre_y (face_centre_y),
        .face_radius   (face_radius),
        .pix_out       (effect_pix)
    );

    assign s2_ready = !s2_valid_reg || !out_stall;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_load  = in_valid && s1_ready;
    assign s2_load  = s1_valid_reg && s2_ready;
    assign in_stall = !s1_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_ready)
        begin
            s1_valid_next = 1'b0;
        end
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_pix_reg <= '{red_in, green_in, blue_in};
            s1_x_reg   <= x_coord;
            s1_y_reg   <= y_coord;
        end
        if (s2_load)
        begin
            s2_pix_reg <= effect_pix;
        end
    end

    assign out_valid = s2_valid_reg;
    assign red_out   = s2_pix_reg.red;
    assign green_out = s2_pix_reg.green;
    assign blue_out  = s2_pix_reg.blue;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid && out_stall))
        else $error("input stalled while the pipeline had room");

    a_full_forces_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid && out_stall) |-> in_stall)
        else $error("input accepted while both pipeline registers were held");

    a_empty_result_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid) |=> out_valid)
        else $error("request in the input register did not advance to an empty result register");

    a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted request was lost from the input register");

endmodule
